// ===== design/sntp_rc_pkg.sv =====
// Shared types and constants for the SNTP reply check and time block.
package sntp_rc_pkg;

  // Field widths.
  localparam int unsigned FreqW  = 41;
  localparam int unsigned CountW = 63;
  localparam int unsigned MsW    = 43;
  localparam int unsigned RttW   = 31;
  // Dividend width: count times 1000 plus half the frequency.
  localparam int unsigned NumW   = 73;

  // Quotient bits resolved by the divider, one per stage.
  localparam int unsigned QuoW   = RttW;
  // Cycles from an accepted word to its result strobe.
  localparam int unsigned Latency = QuoW + 3;

  localparam logic [31:0]      EpochDeltaS = 32'd2208988800;
  localparam logic [9:0]       MsPerS      = 10'd1000;
  localparam logic [RttW-1:0]  RttMax      = {RttW{1'b1}};
  localparam logic [7:0]       StratumMax  = 8'd16;
  localparam logic [1:0]       LeapAlarm   = 2'h3;
  localparam logic [2:0]       ModeServer  = 3'h4;
  localparam logic [2:0]       Version3    = 3'h3;
  localparam logic [2:0]       Version4    = 3'h4;

  // Reply status codes.
  typedef enum logic [2:0] {
    StatOk      = 3'd0,
    StatShort   = 3'd1,
    StatAlarm   = 3'd2,
    StatVersion = 3'd3,
    StatMode    = 3'd4,
    StatStratum = 3'd5,
    StatZeroTs  = 3'd6,
    StatNoFreq  = 3'd7
  } status_e;

  // Data that rides alongside the divider.
  typedef struct packed {
    status_e                  status;
    logic signed [MsW-1:0]    t3_ms;
    logic [MsW-1:0]           proc_ms;
    logic [CountW-1:0]        anchor;
  } side_t;

  // Divider working set for one stage.
  typedef struct packed {
    logic [NumW-1:0]  rem;
    logic [QuoW-1:0]  quo;
    logic             sat;
    logic [FreqW-1:0] freq;
  } div_t;

endpackage

// ===== design/sntp_reply_check_and_time_top.sv =====
// Top level of the SNTP reply check and time calculation block.
//
//  Channel   Handshake                     Word
//  request   start, busy (always low)      parsed reply fields and counters
//  config    cfg_valid_i, cfg_ready_o      cfg_data_i (counter frequency)
//  result    result_valid_o (one cycle)    ok_o, status_o, utc_ms_o, ...
//
// One word is taken every cycle; its result strobes at the end of the pipeline.
// The depth is set by the round trip divider, which resolves one
// quotient bit per stage over 31 stages, plus two front stages and
// one output stage. Reset clears the valid bits and loads the counter
// frequency with 10000000. The receiver cannot stall, so nothing waits.
module sntp_reply_check_and_time_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sntp_rc_pkg::FreqW-1:0]     cfg_data_i,
  input  logic                              reply_complete_i,
  input  logic [7:0]                        header_byte_i,
  input  logic [7:0]                        stratum_i,
  input  logic [31:0]                       recv_seconds_i,
  input  logic [31:0]                       recv_fraction_i,
  input  logic [31:0]                       xmit_seconds_i,
  input  logic [31:0]                       xmit_fraction_i,
  input  logic [sntp_rc_pkg::CountW-1:0]    send_count_i,
  input  logic [sntp_rc_pkg::CountW-1:0]    receive_count_i,
  output logic                              result_valid_o,
  output logic                              ok_o,
  output logic [2:0]                        status_o,
  output logic signed [sntp_rc_pkg::MsW-1:0] utc_ms_o,
  output logic [sntp_rc_pkg::CountW-1:0]    anchor_count_o,
  output logic [sntp_rc_pkg::RttW-1:0]      round_trip_ms_o
);

  logic [sntp_rc_pkg::FreqW-1:0] freq_q;

  logic               fr_valid;
  sntp_rc_pkg::div_t  fr_div;
  sntp_rc_pkg::side_t fr_side;
  logic               dv_valid;
  sntp_rc_pkg::div_t  dv_div;
  sntp_rc_pkg::side_t dv_side;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Counter frequency register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= sntp_rc_pkg::FreqW'(10000000);
    end else if (cfg_valid_i && cfg_ready_o) begin
      freq_q <= cfg_data_i;
    end
  end

  sntp_rc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (start && !busy),
    .freq_i           (freq_q),
    .reply_complete_i (reply_complete_i),
    .header_byte_i    (header_byte_i),
    .stratum_i        (stratum_i),
    .recv_seconds_i   (recv_seconds_i),
    .recv_fraction_i  (recv_fraction_i),
    .xmit_seconds_i   (xmit_seconds_i),
    .xmit_fraction_i  (xmit_fraction_i),
    .send_count_i     (send_count_i),
    .receive_count_i  (receive_count_i),
    .valid_o          (fr_valid),
    .div_o            (fr_div),
    .side_o           (fr_side)
  );

  sntp_rc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .div_i   (fr_div),
    .side_i  (fr_side),
    .valid_o (dv_valid),
    .div_o   (dv_div),
    .side_o  (dv_side)
  );

  // Network round trip and UTC at the receive moment.
  logic [sntp_rc_pkg::RttW-1:0]        rtt;
  logic signed [sntp_rc_pkg::MsW:0]    net;
  logic [sntp_rc_pkg::MsW-1:0]         net_pos;
  logic signed [sntp_rc_pkg::MsW:0]    utc_full;
  logic                                ok_d, ok_q;
  logic [2:0]                          status_d, status_q;
  logic signed [sntp_rc_pkg::MsW-1:0]  utc_d, utc_q;
  logic [sntp_rc_pkg::CountW-1:0]      anchor_d, anchor_q;
  logic [sntp_rc_pkg::RttW-1:0]        rtt_d, rtt_q;
  logic                                valid_q;

  always_comb begin
    rtt      = dv_div.sat ? sntp_rc_pkg::RttMax : dv_div.quo;
    net      = $signed({13'b0, rtt}) - $signed({1'b0, dv_side.proc_ms});
    net_pos  = net[sntp_rc_pkg::MsW] ? '0 : net[sntp_rc_pkg::MsW-1:0];
    utc_full = {dv_side.t3_ms[sntp_rc_pkg::MsW-1], dv_side.t3_ms}
               + $signed({2'b0, net_pos[sntp_rc_pkg::MsW-1:1]});
    ok_d     = dv_side.status == sntp_rc_pkg::StatOk;
    status_d = dv_side.status;
    utc_d    = ok_d ? utc_full[sntp_rc_pkg::MsW-1:0] : '0;
    anchor_d = ok_d ? dv_side.anchor : '0;
    rtt_d    = ok_d ? rtt : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q     <= ok_d;
    status_q <= status_d;
    utc_q    <= utc_d;
    anchor_q <= anchor_d;
    rtt_q    <= rtt_d;
  end

  assign result_valid_o  = valid_q;
  assign ok_o            = ok_q;
  assign status_o        = status_q;
  assign utc_ms_o        = utc_q;
  assign anchor_count_o  = anchor_q;
  assign round_trip_ms_o = rtt_q;

  // A result appears exactly one pipeline depth after its request word.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(sntp_rc_pkg::Latency) result_valid_o)
    else $error("result strobe missing after request");

  // ok and status agree.
  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (ok_o == (status_o == sntp_rc_pkg::StatOk)))
    else $error("ok and status disagree");

  // A failed reply carries zero times.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !ok_o) |->
      (utc_ms_o == '0 && anchor_count_o == '0 && round_trip_ms_o == '0))
    else $error("failed reply with nonzero payload");

endmodule

// ===== design/sntp_rc_front.sv =====
// Front stages: reply checks, timestamp conversion and dividend setup.
module sntp_rc_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [sntp_rc_pkg::FreqW-1:0]        freq_i,
  input  logic                                 reply_complete_i,
  input  logic [7:0]                           header_byte_i,
  input  logic [7:0]                           stratum_i,
  input  logic [31:0]                          recv_seconds_i,
  input  logic [31:0]                          recv_fraction_i,
  input  logic [31:0]                          xmit_seconds_i,
  input  logic [31:0]                          xmit_fraction_i,
  input  logic [sntp_rc_pkg::CountW-1:0]       send_count_i,
  input  logic [sntp_rc_pkg::CountW-1:0]       receive_count_i,
  output logic                                 valid_o,
  output sntp_rc_pkg::div_t                    div_o,
  output sntp_rc_pkg::side_t                   side_o
);

  // Stage one registers.
  logic                                  v1_q;
  sntp_rc_pkg::status_e                  status1_d, status1_q;
  logic [sntp_rc_pkg::CountW-1:0]        ticks1_d, ticks1_q;
  logic signed [sntp_rc_pkg::MsW-1:0]    t2_ms1_d, t2_ms1_q;
  logic signed [sntp_rc_pkg::MsW-1:0]    t3_ms1_d, t3_ms1_q;
  logic [sntp_rc_pkg::CountW-1:0]        anchor1_q;
  logic [sntp_rc_pkg::FreqW-1:0]         freq1_q;

  // Stage two registers.
  logic                                  v2_q;
  sntp_rc_pkg::div_t                     div2_d, div2_q;
  sntp_rc_pkg::side_t                    side2_d, side2_q;

  logic [1:0] leap;
  logic [2:0] ver;
  logic [2:0] mode;

  // NTP seconds and fraction to Unix milliseconds.
  function automatic logic signed [sntp_rc_pkg::MsW-1:0] to_unix_ms(
    input logic [31:0] sec,
    input logic [31:0] frac
  );
    logic signed [43:0] whole;
    logic [41:0]        part;
    logic signed [43:0] sum;
    whole = ($signed({12'b0, sec}) - $signed({12'b0, sntp_rc_pkg::EpochDeltaS}))
            * $signed({34'b0, sntp_rc_pkg::MsPerS});
    part  = {10'b0, frac} * {32'b0, sntp_rc_pkg::MsPerS};
    sum   = whole + $signed({34'b0, part[41:32]});
    return sum[sntp_rc_pkg::MsW-1:0];
  endfunction

  // Checks in priority order, ticks and timestamps.
  always_comb begin
    leap = header_byte_i[7:6];
    ver  = header_byte_i[5:3];
    mode = header_byte_i[2:0];
    if (!reply_complete_i) begin
      status1_d = sntp_rc_pkg::StatShort;
    end else if (leap == sntp_rc_pkg::LeapAlarm) begin
      status1_d = sntp_rc_pkg::StatAlarm;
    end else if (ver != sntp_rc_pkg::Version3 && ver != sntp_rc_pkg::Version4) begin
      status1_d = sntp_rc_pkg::StatVersion;
    end else if (mode != sntp_rc_pkg::ModeServer) begin
      status1_d = sntp_rc_pkg::StatMode;
    end else if (stratum_i == 8'd0 || stratum_i >= sntp_rc_pkg::StratumMax) begin
      status1_d = sntp_rc_pkg::StatStratum;
    end else if (recv_seconds_i == 32'd0 || xmit_seconds_i == 32'd0) begin
      status1_d = sntp_rc_pkg::StatZeroTs;
    end else if (freq_i == '0) begin
      status1_d = sntp_rc_pkg::StatNoFreq;
    end else begin
      status1_d = sntp_rc_pkg::StatOk;
    end
    // A counter that did not advance gives zero ticks and so a zero round trip.
    ticks1_d = (receive_count_i > send_count_i) ? receive_count_i - send_count_i : '0;
    t2_ms1_d = to_unix_ms(recv_seconds_i, recv_fraction_i);
    t3_ms1_d = to_unix_ms(xmit_seconds_i, xmit_fraction_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    status1_q <= status1_d;
    ticks1_q  <= ticks1_d;
    t2_ms1_q  <= t2_ms1_d;
    t3_ms1_q  <= t3_ms1_d;
    anchor1_q <= receive_count_i;
    freq1_q   <= freq_i;
    div2_q    <= div2_d;
    side2_q   <= side2_d;
  end

  // Rounded dividend, saturation test and server processing time.
  logic signed [sntp_rc_pkg::MsW:0] proc_full;
  always_comb begin
    div2_d.rem  = {10'b0, ticks1_q} * {63'b0, sntp_rc_pkg::MsPerS}
                  + {33'b0, freq1_q[sntp_rc_pkg::FreqW-1:1]};
    div2_d.sat  = div2_d.rem >= ({32'b0, freq1_q} << sntp_rc_pkg::QuoW);
    div2_d.quo  = '0;
    div2_d.freq = freq1_q;
    proc_full   = {t3_ms1_q[sntp_rc_pkg::MsW-1], t3_ms1_q}
                  - {t2_ms1_q[sntp_rc_pkg::MsW-1], t2_ms1_q};
    side2_d.status  = status1_q;
    side2_d.t3_ms   = t3_ms1_q;
    side2_d.proc_ms = proc_full[sntp_rc_pkg::MsW] ? '0 : proc_full[sntp_rc_pkg::MsW-1:0];
    side2_d.anchor  = anchor1_q;
  end

  assign valid_o = v2_q;
  assign div_o   = div2_q;
  assign side_o  = side2_q;

endmodule

// ===== design/sntp_rc_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module sntp_rc_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  sntp_rc_pkg::div_t   div_i,
  input  sntp_rc_pkg::side_t  side_i,
  output logic                valid_o,
  output sntp_rc_pkg::div_t   div_o,
  output sntp_rc_pkg::side_t  side_o
);

  localparam int unsigned Steps = sntp_rc_pkg::QuoW;

  logic               valid_q [0:Steps];
  sntp_rc_pkg::div_t  div_q   [0:Steps];
  sntp_rc_pkg::side_t side_q  [0:Steps];

  assign valid_q[0] = valid_i;
  assign div_q[0]   = div_i;
  assign side_q[0]  = side_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int unsigned Bit = Steps - 1 - k;
    logic [sntp_rc_pkg::NumW-1:0] dsor;
    sntp_rc_pkg::div_t            div_d;

    // Try to subtract the divisor shifted to this quotient bit.
    always_comb begin
      dsor  = {32'b0, div_q[k].freq} << Bit;
      div_d = div_q[k];
      if (!div_q[k].sat && div_q[k].rem >= dsor) begin
        div_d.rem      = div_q[k].rem - dsor;
        div_d.quo[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      div_q[k+1]  <= div_d;
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = valid_q[Steps];
  assign div_o   = div_q[Steps];
  assign side_o  = side_q[Steps];

endmodule

// ===== sim/sntp_reply_check_and_time_checker.sv =====
// Checker that predicts and compares every result word of the SNTP reply block.
module sntp_reply_check_and_time_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_o,
  input  logic [sntp_rc_pkg::FreqW-1:0]         cfg_data_i,
  input  logic                                  reply_complete_i,
  input  logic [7:0]                            header_byte_i,
  input  logic [7:0]                            stratum_i,
  input  logic [31:0]                           recv_seconds_i,
  input  logic [31:0]                           recv_fraction_i,
  input  logic [31:0]                           xmit_seconds_i,
  input  logic [31:0]                           xmit_fraction_i,
  input  logic [sntp_rc_pkg::CountW-1:0]        send_count_i,
  input  logic [sntp_rc_pkg::CountW-1:0]        receive_count_i,
  input  logic                                  result_valid_o,
  input  logic                                  ok_o,
  input  logic [2:0]                            status_o,
  input  logic signed [sntp_rc_pkg::MsW-1:0]    utc_ms_o,
  input  logic [sntp_rc_pkg::CountW-1:0]        anchor_count_o,
  input  logic [sntp_rc_pkg::RttW-1:0]          round_trip_ms_o,
  output int                                    fail_count,
  output int                                    pending_replies,
  output int                                    replies_done,
  output int                                    replies_ok
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                              ok;
    sntp_rc_pkg::status_e              status;
    logic [sntp_rc_pkg::MsW-1:0]       utc;
    logic [sntp_rc_pkg::CountW-1:0]    anchor;
    logic [sntp_rc_pkg::RttW-1:0]      rtt;
  } reply_time_t;

  reply_time_t   time_q[$];
  logic [sntp_rc_pkg::FreqW-1:0] freq_model;

  // Convert an NTP timestamp to Unix milliseconds.
  function automatic longint ntp_ms(logic [31:0] sec, logic [31:0] frac);
    logic [63:0] part;
    part = ({32'd0, frac} * 64'd1000) >> 32;
    return (longint'({32'd0, sec}) - 64'sd2208988800) * 1000 + longint'(part);
  endfunction

  // Rounded, clamped round trip in milliseconds.
  function automatic logic [63:0] rtt_ms(logic [63:0] ticks, logic [63:0] f);
    logic [63:0] q, r, extra;
    q = ticks / f;
    r = ticks % f;
    if (q > 64'd2147483) return 64'h7fffffff;
    extra = (r * 1000 + f / 2) / f;
    q = q * 1000 + extra;
    return (q > 64'h7fffffff) ? 64'h7fffffff : q;
  endfunction

  function automatic reply_time_t predict_reply_time();
    reply_time_t e;
    logic [1:0] leap;
    logic [2:0] ver, mode;
    longint t2, t3, proc, net;
    logic [63:0] rtt;
    leap = header_byte_i[7:6];
    ver  = header_byte_i[5:3];
    mode = header_byte_i[2:0];
    e = '{ok: 1'b0, status: sntp_rc_pkg::StatOk, utc: '0, anchor: '0, rtt: '0};
    if (!reply_complete_i) e.status = sntp_rc_pkg::StatShort;
    else if (leap == sntp_rc_pkg::LeapAlarm) e.status = sntp_rc_pkg::StatAlarm;
    else if (ver != sntp_rc_pkg::Version3 && ver != sntp_rc_pkg::Version4)
      e.status = sntp_rc_pkg::StatVersion;
    else if (mode != sntp_rc_pkg::ModeServer) e.status = sntp_rc_pkg::StatMode;
    else if (stratum_i == 8'd0 || stratum_i >= sntp_rc_pkg::StratumMax)
      e.status = sntp_rc_pkg::StatStratum;
    else if (recv_seconds_i == 0 || xmit_seconds_i == 0) e.status = sntp_rc_pkg::StatZeroTs;
    else if (freq_model == 0) e.status = sntp_rc_pkg::StatNoFreq;
    if (e.status != sntp_rc_pkg::StatOk) return e;
    t2 = ntp_ms(recv_seconds_i, recv_fraction_i);
    t3 = ntp_ms(xmit_seconds_i, xmit_fraction_i);
    rtt = (receive_count_i > send_count_i) ?
          rtt_ms({1'b0, receive_count_i - send_count_i}, {23'd0, freq_model}) : 64'd0;
    proc = t3 - t2;
    if (proc < 0) proc = 0;
    net = longint'(rtt) - proc;
    if (net < 0) net = 0;
    e.ok     = 1'b1;
    e.utc    = sntp_rc_pkg::MsW'(t3 + net / 2);
    e.anchor = receive_count_i;
    e.rtt    = rtt[sntp_rc_pkg::RttW-1:0];
    return e;
  endfunction

  assign pending_replies = time_q.size();

  // Track the frequency register, predict on each accepted word, compare results.
  always @(posedge clk_i or negedge rst_ni) begin
    reply_time_t e;
    if (!rst_ni) begin
      freq_model   <= sntp_rc_pkg::FreqW'(10000000);
      fail_count   <= 0;
      replies_done <= 0;
      replies_ok   <= 0;
      time_q.delete();
    end else begin
      if (result_valid_o) begin
        if (time_q.size() == 0) begin
          $error("result word with no reply pending");
          fail_count <= fail_count + 1;
        end else begin
          e = time_q.pop_front();
          replies_done <= replies_done + 1;
          if (e.ok) replies_ok <= replies_ok + 1;
          if (ok_o !== e.ok || status_o !== e.status || utc_ms_o !== e.utc ||
              anchor_count_o !== e.anchor || round_trip_ms_o !== e.rtt) begin
            if (ok_o !== e.ok) $error("ok: expected %0d actual %0d", e.ok, ok_o);
            if (status_o !== e.status)
              $error("status: expected %0d actual %0d", e.status, status_o);
            if (utc_ms_o !== e.utc)
              $error("utc_ms: expected %0d actual %0d", $signed(e.utc), utc_ms_o);
            if (anchor_count_o !== e.anchor)
              $error("anchor_count: expected %0d actual %0d", e.anchor, anchor_count_o);
            if (round_trip_ms_o !== e.rtt)
              $error("round_trip_ms: expected %0d actual %0d", e.rtt, round_trip_ms_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) time_q.push_back(predict_reply_time());
      if (cfg_valid_i && cfg_ready_o) freq_model <= cfg_data_i;
    end
  end
endmodule

// ===== sim/sntp_reply_check_and_time_top_tb.sv =====
// Stimulus and verdict for the SNTP reply check and time block.
module sntp_reply_check_and_time_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [sntp_rc_pkg::FreqW-1:0]   cfg_data_i = '0;
  logic               reply_complete_i = 1'b0;
  logic [7:0]         header_byte_i = '0;
  logic [7:0]         stratum_i = '0;
  logic [31:0]        recv_seconds_i = '0;
  logic [31:0]        recv_fraction_i = '0;
  logic [31:0]        xmit_seconds_i = '0;
  logic [31:0]        xmit_fraction_i = '0;
  logic [sntp_rc_pkg::CountW-1:0]  send_count_i = '0;
  logic [sntp_rc_pkg::CountW-1:0]  receive_count_i = '0;
  logic               result_valid_o;
  logic               ok_o;
  logic [2:0]         status_o;
  logic signed [sntp_rc_pkg::MsW-1:0] utc_ms_o;
  logic [sntp_rc_pkg::CountW-1:0]  anchor_count_o;
  logic [sntp_rc_pkg::RttW-1:0]    round_trip_ms_o;
  int                 fail_count, pending_replies, replies_done, replies_ok;
  int                 sent_words = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sntp_reply_check_and_time_top i_dut (.*);
  sntp_reply_check_and_time_checker i_checker (.*);

  // Draw a value of up to 64 bits.
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Present one reply word and wait until it is taken; start stays high afterwards.
  task automatic send_reply(logic rc, logic [7:0] hdr, logic [7:0] strat,
                            logic [31:0] t2s, logic [31:0] t2f,
                            logic [31:0] t3s, logic [31:0] t3f,
                            logic [sntp_rc_pkg::CountW-1:0] c1,
                            logic [sntp_rc_pkg::CountW-1:0] c4, bit idle_ok);
    while (idle_ok && $urandom_range(99) < 7) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start            <= 1'b1;
    reply_complete_i <= rc;
    header_byte_i    <= hdr;
    stratum_i        <= strat;
    recv_seconds_i   <= t2s;
    recv_fraction_i  <= t2f;
    xmit_seconds_i   <= t3s;
    xmit_fraction_i  <= t3f;
    send_count_i     <= c1;
    receive_count_i  <= c4;
    do @(posedge clk_i); while (busy);
    sent_words++;
  endtask

  // Random reply, mostly well formed with plausible timestamps.
  task automatic send_random_reply(bit idle_ok);
    logic [7:0] hdr, strat;
    logic [31:0] t2s, t3s;
    logic [sntp_rc_pkg::CountW-1:0] c1, c4;
    if ($urandom_range(9) < 8) begin
      hdr   = {$urandom_range(2) == 0 ? 2'd0 : 2'($urandom_range(2)),
               $urandom_range(1) ? sntp_rc_pkg::Version4 : sntp_rc_pkg::Version3,
               sntp_rc_pkg::ModeServer};
      strat = 8'($urandom_range(15, 1));
      t2s   = $urandom_range(3) == 0 ? $urandom() : 32'hE800_0000 + $urandom_range(1 << 20);
      t3s   = $urandom_range(3) == 0 ? $urandom() : t2s + $urandom_range(2);
      if (t2s == 0) t2s = 1;
      if (t3s == 0) t3s = 1;
    end else begin
      hdr = 8'($urandom());
      strat = 8'($urandom());
      t2s = $urandom_range(1) ? 32'd0 : $urandom();
      t3s = $urandom();
    end
    c1 = sntp_rc_pkg::CountW'(rand64());
    case ($urandom_range(3))
      0: c4 = sntp_rc_pkg::CountW'(rand64());
      1: c4 = c1 - sntp_rc_pkg::CountW'($urandom_range(1000));
      default: c4 = c1 + sntp_rc_pkg::CountW'($urandom_range(32'h0fff_ffff));
    endcase
    send_reply($urandom_range(19) != 0, hdr, strat, t2s, $urandom(), t3s, $urandom(),
               c1, c4, idle_ok);
  endtask

  // Stop sending, wait for the pipeline to drain, then write the frequency register.
  task automatic write_freq(logic [sntp_rc_pkg::FreqW-1:0] f);
    start <= 1'b0;
    while (pending_replies != 0) @(posedge clk_i);
    repeat (sntp_rc_pkg::Latency + 2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= f;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [sntp_rc_pkg::FreqW-1:0] freq_set[5];
    int lap;
    freq_set = '{sntp_rc_pkg::FreqW'(1), {sntp_rc_pkg::FreqW{1'b1}},
                 sntp_rc_pkg::FreqW'(1000), sntp_rc_pkg::FreqW'(10000000),
                 sntp_rc_pkg::FreqW'(41'h100_0000_0000)};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each check failing in turn, extremes at the reset frequency, then a zero frequency.
    send_reply(0, 8'h24, 1, 1, 0, 1, 0, 0, 1, 0);
    send_reply(1, 8'hE4, 1, 1, 0, 1, 0, 0, 1, 0);
    send_reply(1, 8'h14, 1, 1, 0, 1, 0, 0, 1, 0);
    send_reply(1, 8'h23, 1, 1, 0, 1, 0, 0, 1, 0);
    send_reply(1, 8'h24, 0, 1, 0, 1, 0, 0, 1, 0);
    send_reply(1, 8'h1C, 16, 1, 0, 1, 0, 0, 1, 0);
    send_reply(1, 8'h24, 255, 1, 0, 1, 0, 0, 1, 0);
    send_reply(1, 8'h24, 1, 0, 0, 1, 0, 0, 1, 0);
    send_reply(1, 8'h24, 15, 5, 0, 0, 0, 0, 1, 0);
    send_reply(1, 8'h9C, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               '0, '1, 0);
    send_reply(1, 8'h64, 2, 1, 0, 1, 0, 5, 5, 0);
    send_reply(1, 8'h24, 2, 32'h8000_0000, 0, 32'h7000_0000, 0, '1, '0, 0);
    send_reply(1, 8'h24, 2, 1, 32'hFFFF_FFFF, 2, 32'h8000_0000, 0, 63'd4999999, 0);
    send_reply(1, 8'h24, 2, 1, 0, 1, 0, 0, 63'd5000, 0);
    write_freq('0);
    send_reply(1, 8'h24, 3, 9, 9, 9, 9, 0, 7, 0);
    send_reply(0, 8'h24, 3, 9, 9, 9, 9, 0, 7, 0);

    // Random laps over several frequency settings, one lap without idling.
    for (lap = 0; lap < 5; lap++) begin
      write_freq(freq_set[lap]);
      repeat (78) send_random_reply(lap != 2);
    end
    // Sender holds off until everything has come back, then continues.
    write_freq(sntp_rc_pkg::FreqW'($urandom_range(32'hffff_ffff, 1)));
    repeat (10) send_random_reply(1);

    start <= 1'b0;
    while (pending_replies != 0) @(posedge clk_i);
    repeat (sntp_rc_pkg::Latency + 4) @(posedge clk_i);
    $display("Sent %0d replies at seven counter frequencies including zero and extremes;",
             sent_words);
    $display("%0d results checked, %0d of them accepted replies.", replies_done, replies_ok);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
